// File: sv/hwor_pkg.sv
// ----------------------------------------------------------------------------
// hwor_pkg
// Shared types and constants for the hit-window odometer ramp sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwor_pkg;

  // Sequencer phase, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WAIT = 5'b00010,
    PH_ODO  = 5'b00100,
    PH_SLOW = 5'b01000,
    PH_REL  = 5'b10000
  } phase_t;

  // Phase codes as reported on the result channel.
  localparam logic [2:0] PHASE_CODE_IDLE = 3'd0;
  localparam logic [2:0] PHASE_CODE_WAIT = 3'd1;
  localparam logic [2:0] PHASE_CODE_ODO  = 3'd2;
  localparam logic [2:0] PHASE_CODE_SLOW = 3'd3;
  localparam logic [2:0] PHASE_CODE_REL  = 3'd4;

  // Transaction modes.
  localparam logic [1:0] MODE_MAIN    = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PAIR_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_TARGET_DISTANCE  = 3'd1;
  localparam logic [2:0] CFG_SLOW_MARGIN      = 3'd2;
  localparam logic [2:0] CFG_SLOW_FLOOR_SPEED = 3'd3;
  localparam logic [2:0] CFG_CRUISE_SPEED     = 3'd4;

  localparam logic [11:0] SINGLE_LEVEL = 12'd80;
  localparam int          RAMP_STEP    = 8;        // 0.5 in Q12.4
  localparam logic [18:0] DIST_K       = 19'd402653; // 0.006 * 2^16 * 2^10
  localparam int          DIST_SHIFT   = 10;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_WAIT: code = PHASE_CODE_WAIT;
      PH_ODO:  code = PHASE_CODE_ODO;
      PH_SLOW: code = PHASE_CODE_SLOW;
      PH_REL:  code = PHASE_CODE_REL;
      default: code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// File: sv/hit_window_odometer_ramp_sequencer.sv
// ----------------------------------------------------------------------------
// hit_window_odometer_ramp_sequencer
// Hit detection window, saturating odometer and speed ramp sequencer.
//
// Each input transaction is one control tick: four sensor levels, two wheel
// speeds, the speed command in force and a mode in tuser (main step, release
// step or clear). Every tick produces exactly one result transaction carrying
// the new speed command (flagged valid in tuser), a done flag and the phase.
// The block takes one tick per clock while the result side keeps up. When a
// result waits at the output, it takes one more tick into the input register
// and then holds tready low until the result drains. A tick passes through
// the input register, then the result register. Hit detection and the distance
// increment multiply are done as the tick enters, so the stage after the
// input register holds only the 48-bit saturating add, the target compares
// and the ramp clamps, which set the clock limit. The user must write
// configuration through cfg_we/cfg_index/cfg_wdata only while no tick is in
// flight; the block does not enforce this. Indexes 5 to 7 are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hit_window_odometer_ramp_sequencer #(
  parameter int WINDOW_TICKS = 250,
  parameter int HITS_NEEDED  = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_side_level[11:0], left_mid_level[23:12], right_mid_level[35:24],
  // right_side_level[47:36], left_wheel_speed[59:48],
  // right_wheel_speed[71:60], current_speed[87:72]
  input  logic [87:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // speed_out[15:0], done_res[16], phase[19:17], zero[23:20]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // speed_valid[0]
  // Configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int WIN_W = $clog2(WINDOW_TICKS + 1);
  localparam int HIT_W = $clog2(HITS_NEEDED + 1);

  // Configuration registers
  logic [11:0] pair_threshold;
  logic [23:0] target_distance;
  logic [23:0] slow_margin;
  logic [10:0] slow_floor_speed;
  logic [14:0] cruise_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_threshold   <= '0;
      target_distance  <= '0;
      slow_margin      <= '0;
      slow_floor_speed <= '0;
      cruise_speed     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hwor_pkg::CFG_PAIR_THRESHOLD:   pair_threshold   <= cfg_wdata[11:0];
        hwor_pkg::CFG_TARGET_DISTANCE:  target_distance  <= cfg_wdata;
        hwor_pkg::CFG_SLOW_MARGIN:      slow_margin      <= cfg_wdata;
        hwor_pkg::CFG_SLOW_FLOOR_SPEED: slow_floor_speed <= cfg_wdata[10:0];
        hwor_pkg::CFG_CRUISE_SPEED:     cruise_speed     <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Entry: decode the hit and form the signed distance increment
  // --------------------------------------------------------------------------
  logic [11:0]        lvl_ls, lvl_lm, lvl_rm, lvl_rs;
  logic signed [12:0] wheel_sum;
  logic [12:0]        wheel_mag;
  logic [31:0]        dist_prod;
  logic [31:0]        dist_round;
  logic [20:0]        inc_mag;
  logic signed [21:0] inc_in;
  logic               hit_in;

  assign lvl_ls = s_axis_tdata[11:0];
  assign lvl_lm = s_axis_tdata[23:12];
  assign lvl_rm = s_axis_tdata[35:24];
  assign lvl_rs = s_axis_tdata[47:36];

  assign hit_in = (lvl_ls > pair_threshold && lvl_rs > pair_threshold) ||
                  lvl_ls > hwor_pkg::SINGLE_LEVEL || lvl_rs > hwor_pkg::SINGLE_LEVEL ||
                  lvl_lm > hwor_pkg::SINGLE_LEVEL || lvl_rm > hwor_pkg::SINGLE_LEVEL;

  assign wheel_sum = 13'($signed(s_axis_tdata[59:48])) +
                     13'($signed(s_axis_tdata[71:60]));
  assign wheel_mag = wheel_sum[12] ? 13'(-wheel_sum) : 13'(wheel_sum);
  // Round half away from zero on the magnitude, then restore the sign.
  assign dist_prod  = 32'(wheel_mag) * 32'(hwor_pkg::DIST_K);
  assign dist_round = dist_prod + 32'(1 << (hwor_pkg::DIST_SHIFT - 1));
  assign inc_mag    = dist_round[hwor_pkg::DIST_SHIFT +: 21];
  assign inc_in     = wheel_sum[12] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               s1_valid;
  logic [1:0]         s1_mode;
  logic               s1_hit;
  logic signed [21:0] s1_inc;
  logic signed [15:0] s1_cur;
  logic               advance;

  // Advance the held tick whenever the result register is free or draining.
  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_mode <= s_axis_tuser;
      s1_hit  <= hit_in;
      s1_inc  <= inc_in;
      s1_cur  <= $signed(s_axis_tdata[87:72]);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  hwor_pkg::phase_t   phase_st, phase_st_next;
  logic [HIT_W-1:0]   hit_count, hit_count_next;
  logic [WIN_W-1:0]   window_count, window_count_next;
  logic signed [47:0] distance_acc, distance_acc_next;
  logic signed [15:0] ramp_speed, ramp_speed_next;

  // Saturating odometer update
  logic signed [48:0] acc_sum;
  logic signed [47:0] dist_sat;
  logic signed [49:0] dist_w, tgt_w, mrg_w;
  logic               reach_slow, reach_tgt;

  assign acc_sum  = 49'(distance_acc) + 49'(s1_inc);
  assign dist_sat = (acc_sum[48] != acc_sum[47]) ?
                    (acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) :
                    acc_sum[47:0];
  assign dist_w   = 50'(dist_sat);
  assign tgt_w    = $signed({18'd0, target_distance, 8'd0});
  assign mrg_w    = $signed({18'd0, slow_margin, 8'd0});
  assign reach_slow = (dist_w + mrg_w) >= tgt_w;
  assign reach_tgt  = dist_w >= tgt_w;

  // Ramp arithmetic
  logic signed [16:0] ramp_w, floor_w, cruise_w, ramp_dn, ramp_up;
  logic [15:0]        slow_ramp;
  logic [15:0]        rel_ramp;
  logic               ramp_at_cruise;

  assign ramp_w    = 17'(ramp_speed);
  assign floor_w   = $signed({2'b00, slow_floor_speed, 4'd0});
  assign cruise_w  = $signed({2'b00, cruise_speed});
  assign ramp_dn   = ramp_w - 17'(hwor_pkg::RAMP_STEP);
  assign ramp_up   = ramp_w + 17'(hwor_pkg::RAMP_STEP);
  assign slow_ramp = (ramp_dn < floor_w) ? floor_w[15:0] : ramp_dn[15:0];
  assign rel_ramp  = (ramp_up > cruise_w) ? cruise_w[15:0] : ramp_up[15:0];
  assign ramp_at_cruise = ramp_w >= cruise_w;

  // Hit window counters, with an idle phase treated as freshly cleared
  logic [HIT_W-1:0] hc_base, hc_inc;
  logic [WIN_W-1:0] wc_base, wc_inc;

  assign hc_base = (phase_st == hwor_pkg::PH_IDLE) ? '0 : hit_count;
  assign wc_base = (phase_st == hwor_pkg::PH_IDLE) ? '0 : window_count;
  assign hc_inc  = hc_base + HIT_W'(s1_hit);
  assign wc_inc  = wc_base + WIN_W'(1);

  logic        res_valid;
  logic [15:0] res_speed;
  logic        res_done;

  always_comb begin
    phase_st_next     = phase_st;
    hit_count_next    = hit_count;
    window_count_next = window_count;
    distance_acc_next = distance_acc;
    ramp_speed_next   = ramp_speed;
    res_valid         = 1'b0;
    res_speed         = '0;
    res_done          = 1'b0;

    case (s1_mode)
      hwor_pkg::MODE_CLEAR: begin
        phase_st_next     = hwor_pkg::PH_IDLE;
        hit_count_next    = '0;
        window_count_next = '0;
        distance_acc_next = '0;
        ramp_speed_next   = '0;
      end

      hwor_pkg::MODE_RELEASE: begin
        if (phase_st == hwor_pkg::PH_REL) begin
          res_valid = 1'b1;
          if (ramp_at_cruise) begin
            res_speed = cruise_w[15:0];
          end else begin
            res_speed       = rel_ramp;
            ramp_speed_next = $signed(rel_ramp);
          end
          // Reaching cruise ends the run: drop back to idle.
          if (ramp_at_cruise || rel_ramp == cruise_w[15:0]) begin
            phase_st_next     = hwor_pkg::PH_IDLE;
            hit_count_next    = '0;
            window_count_next = '0;
            distance_acc_next = '0;
            ramp_speed_next   = '0;
          end
        end
      end

      hwor_pkg::MODE_MAIN: begin
        case (phase_st)
          hwor_pkg::PH_IDLE, hwor_pkg::PH_WAIT: begin
            phase_st_next     = hwor_pkg::PH_WAIT;
            hit_count_next    = hc_base;
            window_count_next = wc_base;
            if (phase_st == hwor_pkg::PH_IDLE) begin
              distance_acc_next = '0;
            end
            if (s1_hit || wc_base != '0) begin
              if (hc_inc >= HIT_W'(HITS_NEEDED)) begin
                hit_count_next    = '0;
                window_count_next = '0;
                distance_acc_next = '0;
                phase_st_next     = hwor_pkg::PH_ODO;
              end else if (wc_inc >= WIN_W'(WINDOW_TICKS)) begin
                hit_count_next    = '0;
                window_count_next = '0;
              end else begin
                hit_count_next    = hc_inc;
                window_count_next = wc_inc;
              end
            end
          end

          hwor_pkg::PH_ODO: begin
            distance_acc_next = dist_sat;
            if (reach_slow) begin
              phase_st_next   = hwor_pkg::PH_SLOW;
              ramp_speed_next = s1_cur;
            end
            if (reach_tgt) begin
              phase_st_next = hwor_pkg::PH_REL;
              res_done      = 1'b1;
            end
          end

          hwor_pkg::PH_SLOW: begin
            distance_acc_next = dist_sat;
            ramp_speed_next   = $signed(slow_ramp);
            res_valid         = 1'b1;
            res_speed         = slow_ramp;
            if (reach_tgt) begin
              phase_st_next = hwor_pkg::PH_REL;
              res_done      = 1'b1;
            end
          end

          hwor_pkg::PH_REL: ;  // hold until release steps arrive

          default: begin
            phase_st_next     = hwor_pkg::PH_IDLE;
            hit_count_next    = '0;
            window_count_next = '0;
            distance_acc_next = '0;
            ramp_speed_next   = '0;
          end
        endcase
      end

      default: ;  // unused mode: hold everything
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_st     <= hwor_pkg::PH_IDLE;
      hit_count    <= '0;
      window_count <= '0;
      distance_acc <= '0;
      ramp_speed   <= '0;
    end else if (advance) begin
      phase_st     <= phase_st_next;
      hit_count    <= hit_count_next;
      window_count <= window_count_next;
      distance_acc <= distance_acc_next;
      ramp_speed   <= ramp_speed_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [15:0] out_speed;
  logic        out_done;
  logic [2:0]  out_phase;
  logic        out_speed_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= advance || (m_axis_tvalid && !m_axis_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_speed       <= res_speed;
      out_done        <= res_done;
      out_phase       <= hwor_pkg::phase_code(phase_st_next);
      out_speed_valid <= res_valid;
    end
  end

  assign m_axis_tdata = {4'd0, out_phase, out_done, out_speed};
  assign m_axis_tuser = out_speed_valid;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hit_count_range: assert property (@(posedge clk) disable iff (rst)
    hit_count < HIT_W'(HITS_NEEDED))
    else $error("hit count reached threshold without leaving wait phase");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    window_count < WIN_W'(WINDOW_TICKS))
    else $error("hit window ran past its length");

  a_counts_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (hit_count != '0 || window_count != '0) |-> phase_st == hwor_pkg::PH_WAIT)
    else $error("hit window counters live outside wait phase");

  a_done_enters_release: assert property (@(posedge clk) disable iff (rst)
    (advance && res_done) |=> phase_st == hwor_pkg::PH_REL)
    else $error("done flagged without entering release phase");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("processed tick produced no result");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hit-window odometer ramp sequencer.
//
// Ticks go in on the input stream, and the results are compared one by one
// against a cycle-free model of the sequencer kept in a small scoreboard
// class. A short directed pass walks the detection, odometry, slow-exit and
// release phases. Random ticks follow; they are shaped from the model's
// current phase so that most runs reach odometry and release. Both stream
// sides idle at random. The register settings change between passes, extremes
// included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int WINDOW_LEN   = 250;
localparam int HITS_TO_ARM  = 8;
localparam int LEVEL_LIMIT  = 80;      // any one level above this is a hit
localparam int HALF_UNIT    = 8;       // 0.5 in Q12.4
localparam longint CM_SCALE = 402653;  // 0.006 * 2^16 * 2^10
localparam int CM_SHIFT     = 10;
localparam longint ODO_TOP  = 64'sh0000_7FFF_FFFF_FFFF;
localparam longint ODO_BOT  = -ODO_TOP - 1;
localparam logic [1:0] MODE_NOP = 2'd3; // unused mode, ignored by the block

class sequencer_model;
  // Register copies
  int pair_thr = 0;
  int target = 0;
  int margin = 0;
  int floor_speed = 0;
  int cruise = 0;
  // Sequencer state
  logic [2:0] phase_q = hwor_pkg::PHASE_CODE_IDLE;
  logic [3:0] hits = 0;
  logic [7:0] window = 0;
  longint distance = 0;
  int ramp = 0;
  // Results owed by the block: {speed_valid, pad, phase, done, speed}
  logic [24:0] pending_results[$];
  int checked = 0;
  int mismatches = 0;

  function void set_reg(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      hwor_pkg::CFG_PAIR_THRESHOLD:   pair_thr = val[11:0];
      hwor_pkg::CFG_TARGET_DISTANCE:  target = val;
      hwor_pkg::CFG_SLOW_MARGIN:      margin = val;
      hwor_pkg::CFG_SLOW_FLOOR_SPEED: floor_speed = val[10:0];
      hwor_pkg::CFG_CRUISE_SPEED:     cruise = val[14:0];
      default: ;
    endcase
  endfunction

  function logic [2:0] phase_now();
    return phase_q;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void clear_state();
    phase_q = hwor_pkg::PHASE_CODE_IDLE;
    hits = 0;
    window = 0;
    distance = 0;
    ramp = 0;
  endfunction

  // Add the sum of the wheel speeds times 0.006 cm, rounded half away from zero.
  function void advance_odometer(input logic signed [11:0] wl, input logic signed [11:0] wr);
    longint sum, mag, next;
    sum = longint'(wl) + longint'(wr);
    mag = (sum < 0) ? -sum : sum;
    mag = (mag * CM_SCALE + (64'sd1 <<< (CM_SHIFT - 1))) >>> CM_SHIFT;
    next = distance + ((sum < 0) ? -mag : mag);
    if (next > ODO_TOP) next = ODO_TOP;
    if (next < ODO_BOT) next = ODO_BOT;
    distance = next;
  endfunction

  // Step the model on one accepted tick and queue the result it owes.
  function void note_tick(input logic [1:0] mode, input logic [87:0] d);
    logic [11:0] ls, lm, rm, rs;
    logic signed [11:0] wl, wr;
    logic signed [15:0] cur;
    logic hit, valid, done;
    logic [15:0] spd;
    longint tgt, mrg;
    int floor_q;
    ls = d[11:0];
    lm = d[23:12];
    rm = d[35:24];
    rs = d[47:36];
    wl = d[59:48];
    wr = d[71:60];
    cur = d[87:72];
    valid = 1'b0;
    done = 1'b0;
    spd = 16'd0;
    tgt = longint'(target) <<< 8;
    mrg = longint'(margin) <<< 8;
    case (mode)
      hwor_pkg::MODE_CLEAR: clear_state();
      hwor_pkg::MODE_RELEASE: begin
        if (phase_q == hwor_pkg::PHASE_CODE_REL) begin
          valid = 1'b1;
          if (ramp >= cruise) begin
            spd = cruise[15:0];
            clear_state();
          end else begin
            ramp = ramp + HALF_UNIT;
            if (ramp > cruise) ramp = cruise;
            spd = ramp[15:0];
            if (ramp >= cruise) clear_state();
          end
        end
      end
      hwor_pkg::MODE_MAIN: begin
        hit = (ls > pair_thr && rs > pair_thr) || ls > LEVEL_LIMIT || rs > LEVEL_LIMIT ||
              lm > LEVEL_LIMIT || rm > LEVEL_LIMIT;
        // An idle tick arms detection and counts as a wait tick at once.
        if (phase_q == hwor_pkg::PHASE_CODE_IDLE) begin
          hits = 0;
          window = 0;
          distance = 0;
          phase_q = hwor_pkg::PHASE_CODE_WAIT;
        end
        if (phase_q == hwor_pkg::PHASE_CODE_WAIT) begin
          if (hit || window != 0) begin
            window = window + 8'd1;
            if (hit) hits = hits + 4'd1;
            if (hits >= HITS_TO_ARM) begin
              hits = 0;
              window = 0;
              distance = 0;
              phase_q = hwor_pkg::PHASE_CODE_ODO;
            end else if (window >= WINDOW_LEN) begin
              hits = 0;
              window = 0;
            end
          end
        end else if (phase_q == hwor_pkg::PHASE_CODE_ODO) begin
          advance_odometer(wl, wr);
          // Slow-down starts from the command in force; nothing is driven yet.
          if (distance + mrg >= tgt) begin
            phase_q = hwor_pkg::PHASE_CODE_SLOW;
            ramp = cur;
          end
          if (distance >= tgt) begin
            phase_q = hwor_pkg::PHASE_CODE_REL;
            done = 1'b1;
          end
        end else if (phase_q == hwor_pkg::PHASE_CODE_SLOW) begin
          floor_q = floor_speed << 4;
          advance_odometer(wl, wr);
          ramp = ramp - HALF_UNIT;
          if (ramp < floor_q) ramp = floor_q;
          valid = 1'b1;
          spd = ramp[15:0];
          if (distance >= tgt) begin
            phase_q = hwor_pkg::PHASE_CODE_REL;
            done = 1'b1;
          end
        end else if (phase_q != hwor_pkg::PHASE_CODE_REL) begin
          clear_state();
        end
      end
      default: ;
    endcase
    pending_results.push_back({valid, 4'd0, phase_q, done, spd});
  endfunction

  task report(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    $display("mismatch on result %0d: %s wanted 0x%0h, got 0x%0h",
             checked, field, want, got);
  endtask

  task check_result(input logic [23:0] data, input logic flag);
    logic [24:0] want;
    if (pending_results.size() == 0) begin
      report("unrequested result", 32'd0, {7'd0, flag, data});
      return;
    end
    want = pending_results.pop_front();
    if (data[15:0] != want[15:0]) report("speed_out", want[15:0], data[15:0]);
    if (data[16] != want[16]) report("done_res", want[16], data[16]);
    if (data[19:17] != want[19:17]) report("phase", want[19:17], data[19:17]);
    if (data[23:20] != 4'd0) report("pad bits", 32'd0, data[23:20]);
    if (flag != want[24]) report("speed_valid", want[24], flag);
    checked++;
  endtask
endclass

module testbench;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // left_side_level[11:0], left_mid_level[23:12], right_mid_level[35:24],
  // right_side_level[47:36], left_wheel_speed[59:48],
  // right_wheel_speed[71:60], current_speed[87:72]
  logic [87:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;   // mode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // speed_out[15:0], done_res[16], phase[19:17], zero[23:20]
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;   // speed_valid[0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  sequencer_model model;

  // Idle percentages for each stream side, and the hit density of the
  // current detection attempt.
  int tx_idle_pct;
  int rx_idle_pct;
  int hit_pct;
  bit held_once = 1'b0;

  hit_window_odometer_ramp_sequencer #(
    .WINDOW_TICKS(WINDOW_LEN),
    .HITS_NEEDED (HITS_TO_ARM)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Sample both streams at the rising edge: feed accepted ticks to the
  // model, and check every accepted result against the oldest one owed.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) model.note_tick(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) model.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Result side: random back-pressure, plus one long hold-off once the
  // run is under way so that the block fills up and stalls its input.
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && model != null && model.checked >= 150) begin
        held_once = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Give up long after the slowest correct run would have finished.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [87:0] pack_tick(input logic [11:0] ls, lm, rm, rs, wl, wr,
                                            input logic [15:0] cur);
    return {cur, wr, wl, rs, rm, lm, ls};
  endfunction

  // Idle each cycle at the sender's idle rate, then offer one tick and hold
  // it until taken.
  task automatic send_tick(input logic [1:0] mode, input logic [87:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed result is back and the pipe is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all five registers back to back; keep the enable high throughout.
  task automatic load_settings(input int thr, input int tgt, input int mrg, input int flr,
                               input int crs);
    logic [2:0] idx [5];
    logic [23:0] val [5];
    idx = '{hwor_pkg::CFG_PAIR_THRESHOLD, hwor_pkg::CFG_TARGET_DISTANCE,
            hwor_pkg::CFG_SLOW_MARGIN, hwor_pkg::CFG_SLOW_FLOOR_SPEED,
            hwor_pkg::CFG_CRUISE_SPEED};
    val = '{24'(thr), 24'(tgt), 24'(mrg), 24'(flr), 24'(crs)};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      model.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random ticks shaped by the model's phase: detection attempts with a
  // chosen hit density, forward motion during odometry, release steps in
  // the release phase, and a sprinkling of clears, no-ops and pure noise.
  task automatic run_random(input int count);
    logic [1:0] mode;
    logic [11:0] lv [4];
    logic [11:0] wl, wr;
    logic [15:0] cur;
    logic [87:0] raw;
    logic [2:0] ph, last_ph;
    int stay, roll, thr, pick;
    last_ph = 3'd7;
    stay = 0;
    repeat (count) begin
      ph = model.phase_now();
      stay = (ph == last_ph) ? stay + 1 : 0;
      // Pick a new hit density for each detection attempt; a sparse one
      // lets the window run out.
      if ((ph == hwor_pkg::PHASE_CODE_IDLE || ph == hwor_pkg::PHASE_CODE_WAIT) &&
          !(last_ph == hwor_pkg::PHASE_CODE_IDLE || last_ph == hwor_pkg::PHASE_CODE_WAIT))
      begin
        pick = $urandom_range(2);
        hit_pct = (pick == 0) ? 3 : (pick == 1) ? 35 : 90;
      end
      last_ph = ph;
      thr = model.pair_thr;

      // Quiet levels by default: nothing above the single limit, no pair.
      for (int i = 0; i < 4; i++) lv[i] = 12'($urandom_range(LEVEL_LIMIT));
      if (lv[0] > thr && lv[3] > thr) lv[3] = thr[11:0];

      roll = $urandom_range(99);
      if (roll < 70) begin
        wl = 12'($urandom_range(2047));
        wr = 12'($urandom_range(2047));
      end else if (roll < 90) begin
        wl = 12'($urandom);
        wr = 12'($urandom);
      end else begin
        wl = 12'($urandom_range(LEVEL_LIMIT));
        wr = 12'($urandom_range(LEVEL_LIMIT));
      end
      if ($urandom_range(99) < 60) cur = 16'($urandom_range(1500));
      else cur = 16'($urandom);

      roll = $urandom_range(99);
      mode = hwor_pkg::MODE_MAIN;
      if (roll < 6) begin
        mode = 2'($urandom_range(3));
        raw[31:0] = $urandom;
        raw[63:32] = $urandom;
        raw[87:64] = 24'($urandom);
      end else begin
        case (ph)
          hwor_pkg::PHASE_CODE_REL: begin
            mode = hwor_pkg::MODE_RELEASE;
            if (roll < 11) mode = hwor_pkg::MODE_MAIN;
            else if (roll < 14) mode = MODE_NOP;
            if (stay > 120) mode = hwor_pkg::MODE_CLEAR;
          end
          hwor_pkg::PHASE_CODE_ODO, hwor_pkg::PHASE_CODE_SLOW: begin
            for (int i = 0; i < 4; i++) lv[i] = 12'($urandom);
            if (roll < 9) mode = hwor_pkg::MODE_RELEASE;
            else if (roll < 11) mode = MODE_NOP;
            else if (roll < 12) mode = hwor_pkg::MODE_CLEAR;
            // Abandon runs that would take too long to reach the target.
            if (stay > 150) mode = hwor_pkg::MODE_CLEAR;
          end
          default: begin
            if (roll < 9) mode = hwor_pkg::MODE_CLEAR;
            else if (roll < 11) mode = hwor_pkg::MODE_RELEASE;
            else if (roll < 13) mode = MODE_NOP;
            if ($urandom_range(99) < hit_pct) begin
              pick = $urandom_range(2);
              if (pick == 0 && thr < 4095) begin
                lv[0] = 12'($urandom_range(4095, thr + 1));
                lv[3] = 12'($urandom_range(4095, thr + 1));
              end else begin
                lv[$urandom_range(3)] = 12'($urandom_range(4095, LEVEL_LIMIT + 1));
              end
            end
          end
        endcase
        raw = pack_tick(lv[0], lv[1], lv[2], lv[3], wl, wr, cur);
      end
      send_tick(mode, raw);
    end
  endtask

  initial begin
    model = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = hwor_pkg::MODE_MAIN;
    cfg_we = 1'b0;
    cfg_index = hwor_pkg::CFG_PAIR_THRESHOLD;
    cfg_wdata = '0;
    tx_idle_pct = 19;
    rx_idle_pct = 50;
    hit_pct = 35;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk through every phase. Target 16000/256 cm with an
    // 8000/256 cm margin takes two full-speed ticks to enter slow exit.
    load_settings(50, 16000, 8000, 3, 200);
    send_tick(MODE_NOP, pack_tick(0, 0, 0, 0, 0, 0, 0));          // no-op while idle
    send_tick(hwor_pkg::MODE_RELEASE, pack_tick(0, 0, 0, 0, 0, 0, 0)); // outside release
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(50, 80, 80, 50, 0, 0, 0)); // arm, at the edge
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(81, 0, 0, 0, 0, 0, 0));    // eight hits
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 81, 0, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 81, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 0, 81, 0, 0, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(51, 0, 0, 51, 0, 0, 0));   // pair above thr
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h800,
                                             12'h7FF, 16'h8000));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 12'hFFF, 0, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 12'hFFF, 0, 0, 0, 0)); // enter odometry
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 0, 0, 12'h7FF, 12'h7FF, 16'h8000));
    send_tick(hwor_pkg::MODE_RELEASE, pack_tick(0, 0, 0, 0, 12'h7FF, 12'h7FF, 0));
    send_tick(hwor_pkg::MODE_MAIN,
              pack_tick(0, 0, 0, 0, 12'h7FF, 12'h7FF, 16'h1234));        // slow exit
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 0, 0, 12'h800, 12'h800, 0)); // back up
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 0, 0, 12'h7FF, 12'h7FF, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(0, 0, 0, 0, 12'h7FF, 12'h7FF, 0)); // done
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(12'hFFF, 0, 0, 0, 0, 0, 0)); // held in release
    send_tick(MODE_NOP, pack_tick(0, 0, 0, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_RELEASE, pack_tick(0, 0, 0, 0, 0, 0, 0)); // ramp above cruise
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(81, 0, 0, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_CLEAR, pack_tick(0, 0, 0, 0, 0, 0, 0));
    send_tick(hwor_pkg::MODE_MAIN, pack_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                                             12'hFFF, 16'hFFFF));
    send_tick(MODE_NOP, pack_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                                  16'hFFFF));
    drain();

    // Random passes; change registers only once the block has gone quiet.
    load_settings($urandom_range(300), $urandom_range(40000), $urandom_range(20000),
                  $urandom_range(40), $urandom_range(800));
    run_random(265);
    drain();
    load_settings(0, 0, 0, 0, 0);
    run_random(265);
    drain();

    tx_idle_pct = 50;
    rx_idle_pct = 19;
    load_settings(4095, 24'hFFFFFF, 24'hFFFFFF, 2047, 32767);
    run_random(265);
    drain();
    load_settings($urandom_range(300), $urandom_range(40000), $urandom_range(20000),
                  $urandom_range(40), $urandom_range(800));
    run_random(265);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings($urandom_range(4095), $urandom_range(40000), $urandom_range(20000),
                  $urandom_range(40), $urandom_range(800));
    run_random(265);
    drain();

    // Let any stray result show up before the verdict.
    repeat (8) @(negedge clk);
    if (model.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/hwor_pkg.sv
sv/hit_window_odometer_ramp_sequencer.sv
sim/testbench.sv
